// ===== hdl/psrs_pkg.sv =====
// Shared types and constants for the five-point relaxation sweep.
// Used by every module of the block; depends on nothing else.
package psrs_pkg;

  localparam logic [1:0] REG_GRID_SIDE  = 2'd0;
  localparam logic [1:0] REG_STEP_SQ    = 2'd1;
  localparam logic [1:0] REG_SWEEP_MODE = 2'd2;

  localparam logic [1:0] MODE_FULL = 2'd0;
  localparam logic [1:0] MODE_EVEN = 2'd1;
  localparam logic [1:0] MODE_ODD  = 2'd2;

  localparam logic [10:0] GRID_SIDE_RST = 11'd33;
  localparam logic [16:0] STEP_SQ_RST   = 17'd64;

  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_PW    = $clog2(OUTQ_DEPTH);
  localparam int OUTQ_CW    = $clog2(OUTQ_DEPTH + 1);

  typedef struct packed {
    logic       last;
    logic [9:0] row;
    logic [9:0] col;
  } node_tag_t;

  typedef struct packed {
    logic      valid;
    logic      emit;
    logic      update;
    node_tag_t tag;
  } stage_ctl_t;

  typedef struct packed {
    node_tag_t   tag;
    logic [31:0] value;
  } result_t;

endpackage

// ===== hdl/poisson_stencil_relaxation_sweep.sv =====
// Top level of the streamed five-point relaxation sweep.
// Depends on psrs_pkg, psrs_regs, psrs_lines, psrs_relax and psrs_outq.
//
// Grid nodes enter in raster order on the input channel (in_valid, in_stall),
// each transaction carrying first_node, solution_value and source_value.
// One result transaction leaves on the output channel (out_valid, out_stall)
// for every interior node, once the node below it has arrived: its row, its
// column, the relaxed or passed-through value and last_node on the final one.
// The block takes one node per cycle while in_stall is low. A result passes
// through the operand and arithmetic registers and then the result queue;
// each line memory is written once per node, and the middle one is read twice.
// Results collect in a four-entry queue; in_stall rises when the queue entries
// and the nodes in the two pipeline stages together reach the queue depth.
// After reset the line memories are cleared at one entry per cycle with
// in_stall held high; configuration writes are accepted during that time.
// The user must write registers through the APB-style port only while the
// block is idle; the block itself does not enforce this.
module poisson_stencil_relaxation_sweep #(
  parameter int MAX_SIDE   = 1024,
  parameter int VALUE_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               first_node,
  input  logic signed [31:0] solution_value,
  input  logic signed [31:0] source_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [9:0]         node_row,
  output logic [9:0]         node_col,
  output logic signed [31:0] relaxed_value,
  output logic               last_node
);

  localparam int VB = (VALUE_BITS < 16) ? 16 : ((VALUE_BITS > 32) ? 32 : VALUE_BITS);
  localparam int XW = ($clog2(MAX_SIDE + 1) > 11) ? $clog2(MAX_SIDE + 1) : 11;
  localparam logic [XW-1:0] SIDE_MIN = XW'(3);
  localparam logic [XW-1:0] SIDE_MAX = XW'(MAX_SIDE);

  logic [10:0]          grid_side;
  logic [16:0]          step_squared;
  logic [1:0]           sweep_mode;
  logic [XW-1:0]        gs_e, side;
  logic                 take, clr_busy, r_valid, push;
  psrs_pkg::stage_ctl_t s1_ctl;
  logic [VB-1:0]        op_up, op_down, op_left, op_right, op_src, op_center;
  psrs_pkg::result_t    push_data, head_data;
  logic [psrs_pkg::OUTQ_CW-1:0] q_count, occupancy;

  psrs_regs u_regs (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .grid_side    (grid_side),
    .step_squared (step_squared),
    .sweep_mode   (sweep_mode)
  );

  assign gs_e = XW'(grid_side);
  assign side = (gs_e < SIDE_MIN) ? SIDE_MIN : ((gs_e > SIDE_MAX) ? SIDE_MAX : gs_e);

  assign occupancy = q_count + psrs_pkg::OUTQ_CW'(s1_ctl.valid)
                   + psrs_pkg::OUTQ_CW'(r_valid);
  assign in_stall  = clr_busy || (occupancy >= psrs_pkg::OUTQ_CW'(psrs_pkg::OUTQ_DEPTH));
  assign take      = in_valid && !in_stall;

  psrs_lines #(
    .MAX_SIDE (MAX_SIDE),
    .VB       (VB),
    .XW       (XW)
  ) u_lines (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .first_node (first_node),
    .u_in       (solution_value[VB-1:0]),
    .f_in       (source_value[VB-1:0]),
    .side       (side),
    .mode       (sweep_mode),
    .clr_busy   (clr_busy),
    .s1_ctl     (s1_ctl),
    .op_up      (op_up),
    .op_down    (op_down),
    .op_left    (op_left),
    .op_right   (op_right),
    .op_src     (op_src),
    .op_center  (op_center)
  );

  psrs_relax #(
    .VB (VB)
  ) u_relax (
    .clk          (clk),
    .rst          (rst),
    .s1_ctl       (s1_ctl),
    .step_squared (step_squared),
    .op_up        (op_up),
    .op_down      (op_down),
    .op_left      (op_left),
    .op_right     (op_right),
    .op_src       (op_src),
    .op_center    (op_center),
    .r_valid      (r_valid),
    .push         (push),
    .push_data    (push_data)
  );

  psrs_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (!out_stall),
    .not_empty (out_valid),
    .head_data (head_data),
    .count     (q_count)
  );

  assign node_row      = head_data.tag.row;
  assign node_col      = head_data.tag.col;
  assign last_node     = head_data.tag.last;
  assign relaxed_value = head_data.value;

endmodule

// ===== hdl/psrs_regs.sv =====
// Configuration registers of the relaxation sweep behind an APB-style port.
// Depends on psrs_pkg for register indexes and reset values.
module psrs_regs (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [10:0] grid_side,
  output logic [16:0] step_squared,
  output logic [1:0]  sweep_mode
);

  logic [1:0] idx;
  logic       wr;

  assign idx    = paddr[3:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_side    <= psrs_pkg::GRID_SIDE_RST;
      step_squared <= psrs_pkg::STEP_SQ_RST;
      sweep_mode   <= psrs_pkg::MODE_FULL;
    end else if (wr) begin
      unique case (idx)
        psrs_pkg::REG_GRID_SIDE:  grid_side    <= pwdata[10:0];
        psrs_pkg::REG_STEP_SQ:    step_squared <= pwdata[16:0];
        psrs_pkg::REG_SWEEP_MODE: sweep_mode   <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      psrs_pkg::REG_GRID_SIDE:  prdata = {21'd0, grid_side};
      psrs_pkg::REG_STEP_SQ:    prdata = {15'd0, step_squared};
      psrs_pkg::REG_SWEEP_MODE: prdata = {30'd0, sweep_mode};
      default:                  prdata = 32'd0;
    endcase
  end

endmodule

// ===== hdl/psrs_lines.sv =====
// Line memories, position counters and operand forwarding of the sweep.
// Depends on psrs_pkg for the stage control struct and mode codes.
module psrs_lines #(
  parameter int MAX_SIDE = 1024,
  parameter int VB       = 32,
  parameter int XW       = 11
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 take,
  input  logic                 first_node,
  input  logic [VB-1:0]        u_in,
  input  logic [VB-1:0]        f_in,
  input  logic [XW-1:0]        side,
  input  logic [1:0]           mode,
  output logic                 clr_busy,
  output psrs_pkg::stage_ctl_t s1_ctl,
  output logic [VB-1:0]        op_up,
  output logic [VB-1:0]        op_down,
  output logic [VB-1:0]        op_left,
  output logic [VB-1:0]        op_right,
  output logic [VB-1:0]        op_src,
  output logic [VB-1:0]        op_center
);

  localparam int CW = $clog2(MAX_SIDE);
  localparam logic [XW:0] ONE     = (XW+1)'(1);
  localparam logic [XW:0] TWO     = (XW+1)'(2);
  localparam logic [XW:0] COL_TOP = (XW+1)'(MAX_SIDE - 1);
  localparam logic [CW-1:0] CLR_TOP = CW'(MAX_SIDE - 1);

  logic [VB-1:0] upper_mem  [MAX_SIDE];
  logic [VB-1:0] middle_mem [MAX_SIDE];
  logic [VB-1:0] source_mem [MAX_SIDE];

  logic [CW-1:0] row_cnt, col_cnt, clr_addr;
  logic [XW:0]   side_e, row_e, col_e, row0, col0, nr, col_inc, row_inc;
  logic [XW:0]   row_next, col_next;
  logic          restart, parity, upd0;
  logic [CW-1:0] addr_c, addr_n;
  psrs_pkg::stage_ctl_t ctl0;

  logic [CW-1:0] s1_col, s1_coln;
  logic [VB-1:0] s1_u, s1_f;
  logic [VB-1:0] mid_c_q, mid_n_q, up_q, src_q;
  logic          fwd_valid;
  logic [CW-1:0] fwd_col;
  logic [VB-1:0] fwd_u, fwd_f, fwd_center;
  logic [VB-1:0] left_value;
  logic          hit_c, hit_n;
  logic [CW-1:0] wr_addr;
  logic [VB-1:0] wr_upper, wr_middle, wr_source;
  logic          wr_en;

  assign side_e = (XW+1)'(side);
  assign row_e  = (XW+1)'(row_cnt);
  assign col_e  = (XW+1)'(col_cnt);

  always_comb begin
    restart = first_node || (row_e >= side_e) || (col_e >= side_e);
    row0    = restart ? '0 : row_e;
    col0    = restart ? '0 : col_e;
    addr_c  = col0[CW-1:0];
    addr_n  = (col0 == COL_TOP) ? '0 : CW'(col0 + ONE);
    nr      = row0 - ONE;
    parity  = nr[0] ^ col0[0];
    case (mode)
      psrs_pkg::MODE_EVEN: upd0 = !parity;
      psrs_pkg::MODE_ODD:  upd0 = parity;
      default:             upd0 = 1'b1;
    endcase
    ctl0.valid    = 1'b1;
    ctl0.emit     = (row0 >= TWO) && (col0 >= ONE) && ((col0 + TWO) <= side_e);
    ctl0.update   = upd0;
    ctl0.tag.row  = nr[9:0];
    ctl0.tag.col  = col0[9:0];
    ctl0.tag.last = ((nr + TWO) == side_e) && ((col0 + TWO) == side_e);
    col_inc = col0 + ONE;
    row_inc = row0 + ONE;
    if (col_inc >= side_e) begin
      col_next = '0;
      row_next = (row_inc >= side_e) ? '0 : row_inc;
    end else begin
      col_next = col_inc;
      row_next = row0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_cnt      <= '0;
      col_cnt      <= '0;
      s1_ctl.valid <= 1'b0;
      clr_busy     <= 1'b1;
      clr_addr     <= '0;
      fwd_valid    <= 1'b0;
      left_value   <= '0;
    end else begin
      s1_ctl.valid <= take;
      fwd_valid    <= s1_ctl.valid;
      if (take) begin
        row_cnt       <= CW'(row_next);
        col_cnt       <= CW'(col_next);
        s1_ctl.emit   <= ctl0.emit;
        s1_ctl.update <= ctl0.update;
        s1_ctl.tag    <= ctl0.tag;
      end
      if (clr_busy) begin
        clr_addr <= clr_addr + CW'(1);
        if (clr_addr == CLR_TOP) begin
          clr_busy <= 1'b0;
        end
      end
      if (s1_ctl.valid) begin
        left_value <= op_center;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_col        <= addr_c;
      s1_coln       <= addr_n;
      s1_u          <= u_in;
      s1_f          <= f_in;
      mid_c_q       <= middle_mem[addr_c];
      mid_n_q       <= middle_mem[addr_n];
      up_q          <= upper_mem[addr_c];
      src_q         <= source_mem[addr_c];
    end
    fwd_col    <= s1_col;
    fwd_u      <= s1_u;
    fwd_f      <= s1_f;
    fwd_center <= op_center;
  end

  assign hit_c     = fwd_valid && (fwd_col == s1_col);
  assign hit_n     = fwd_valid && (fwd_col == s1_coln);
  assign op_center = hit_c ? fwd_u : mid_c_q;
  assign op_up     = hit_c ? fwd_center : up_q;
  assign op_src    = hit_c ? fwd_f : src_q;
  assign op_right  = hit_n ? fwd_u : mid_n_q;
  assign op_down   = s1_u;
  assign op_left   = left_value;

  assign wr_en     = clr_busy || s1_ctl.valid;
  assign wr_addr   = clr_busy ? clr_addr : s1_col;
  assign wr_upper  = clr_busy ? '0 : op_center;
  assign wr_middle = clr_busy ? '0 : s1_u;
  assign wr_source = clr_busy ? '0 : s1_f;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      upper_mem[wr_addr]  <= wr_upper;
      middle_mem[wr_addr] <= wr_middle;
      source_mem[wr_addr] <= wr_source;
    end
  end

endmodule

// ===== hdl/psrs_relax.sv =====
// Relaxation arithmetic: h2*f plus the neighbour sum, divided by four,
// rounded and saturated. Depends on psrs_pkg for the control and result types.
module psrs_relax #(
  parameter int VB = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  psrs_pkg::stage_ctl_t s1_ctl,
  input  logic [16:0]          step_squared,
  input  logic [VB-1:0]        op_up,
  input  logic [VB-1:0]        op_down,
  input  logic [VB-1:0]        op_left,
  input  logic [VB-1:0]        op_right,
  input  logic [VB-1:0]        op_src,
  input  logic [VB-1:0]        op_center,
  output logic                 r_valid,
  output logic                 push,
  output psrs_pkg::result_t    push_data
);

  localparam int NW = VB + 20;

  logic signed [VB+1:0]  sum;
  logic signed [VB+17:0] prod;
  logic signed [VB+1:0]  r_sum;
  logic signed [VB+17:0] r_prod;
  logic signed [VB-1:0]  r_center;
  psrs_pkg::stage_ctl_t  r_ctl;
  logic signed [NW-1:0]  num, q;
  logic [20:0]           hi;
  logic signed [VB-1:0]  sat, val;

  assign sum = (VB+2)'($signed(op_up)) + (VB+2)'($signed(op_down))
             + (VB+2)'($signed(op_left)) + (VB+2)'($signed(op_right));
  assign prod = $signed({1'b0, step_squared}) * $signed(op_src);

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else begin
      r_valid <= s1_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    r_ctl    <= s1_ctl;
    r_sum    <= sum;
    r_prod   <= prod;
    r_center <= $signed(op_center);
  end

  always_comb begin
    num = NW'(r_prod) + (NW'(r_sum) <<< 16);
    q   = (num + NW'(1 << 17)) >>> 18;
    hi  = q[NW-1:VB-1];
    if ((&hi) || !(|hi)) begin
      sat = q[VB-1:0];
    end else if (q[NW-1]) begin
      sat = {1'b1, {(VB-1){1'b0}}};
    end else begin
      sat = {1'b0, {(VB-1){1'b1}}};
    end
    val = r_ctl.update ? sat : r_center;
  end

  assign push            = r_valid && r_ctl.emit;
  assign push_data.tag   = r_ctl.tag;
  assign push_data.value = 32'(val);

endmodule

// ===== hdl/psrs_outq.sv =====
// Small result queue that decouples the pipeline from the output stall.
// Depends on psrs_pkg for its depth and entry type.
module psrs_outq (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  input  psrs_pkg::result_t               push_data,
  input  logic                            pop,
  output logic                            not_empty,
  output psrs_pkg::result_t               head_data,
  output logic [psrs_pkg::OUTQ_CW-1:0]    count
);

  psrs_pkg::result_t                entries [psrs_pkg::OUTQ_DEPTH];
  logic [psrs_pkg::OUTQ_PW-1:0]     rd_ptr, wr_ptr;
  logic                             do_pop;

  assign not_empty = (count != '0);
  assign do_pop    = pop && not_empty;
  assign head_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + psrs_pkg::OUTQ_PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + psrs_pkg::OUTQ_PW'(1);
      end
      if (push && !do_pop) begin
        count <= count + psrs_pkg::OUTQ_CW'(1);
      end else if (do_pop && !push) begin
        count <= count - psrs_pkg::OUTQ_CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== tb/sv/tb_poisson_stencil_relaxation_sweep.sv =====
// Self-checking testbench for the streamed five-point relaxation sweep.
// Depends on psrs_pkg and poisson_stencil_relaxation_sweep; it has its own line-buffer
// predictor, a directed table followed by random grid streams, and random idling.
module tb_poisson_stencil_relaxation_sweep;

  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int unsigned SIDE_LIMIT = 1024;
  localparam int unsigned SHRINK_FROM = 48;
  localparam int unsigned RANDOM_NODES = 1900;
  localparam int unsigned CALM_FROM = 1500;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam logic [31:0] ONE = 32'h0001_0000;
  localparam logic [31:0] PEAK = 32'h7FFF_FFFF;

  typedef enum logic { ROW_NODE, ROW_CFG } row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [1:0]  idx;
    logic [31:0] wdata;
    bit          first;
    logic [31:0] u;
    logic [31:0] f;
    bit          typed;
    logic [31:0] want;
    bit          want_last;
  } directed_row_t;

  typedef struct packed {
    logic [9:0]  row;
    logic [9:0]  col;
    logic [31:0] value;
    logic        last;
  } relax_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [3:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               first_node = 1'b0;
  logic signed [31:0] solution_value = '0;
  logic signed [31:0] source_value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [9:0]         node_row;
  logic [9:0]         node_col;
  logic signed [31:0] relaxed_value;
  logic               last_node;

  poisson_stencil_relaxation_sweep DUT (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .first_node(first_node),
    .solution_value(solution_value), .source_value(source_value),
    .out_valid(out_valid), .out_stall(out_stall), .node_row(node_row),
    .node_col(node_col), .relaxed_value(relaxed_value), .last_node(last_node)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [10:0] side_cfg = psrs_pkg::GRID_SIDE_RST;
  logic [16:0] h2_cfg = psrs_pkg::STEP_SQ_RST;
  logic [1:0]  mode_cfg = psrs_pkg::MODE_FULL;

  longint      u_two_up [SIDE_LIMIT];
  longint      u_one_up [SIDE_LIMIT];
  longint      f_one_up [SIDE_LIMIT];
  longint      u_left = 0;
  longint      u_here = 0;
  int unsigned at_row = 0;
  int unsigned at_col = 0;

  relax_result_t pending_results [$];
  int unsigned   mismatches = 0;
  int unsigned   quiet_cycles = 0;
  int unsigned   stall_cycles = 0;
  bit            stall_on = 1'b0;
  bit            gaps_on = 1'b0;
  directed_row_t directed_rows [30];

  function automatic int unsigned clamped_side();
    if (side_cfg < 3) return 3;
    if (side_cfg > SIDE_LIMIT) return SIDE_LIMIT;
    return 32'(side_cfg);
  endfunction

  function automatic logic [31:0] stencil_average(input longint up, dn, lf, rt, src);
    longint num, q;
    num = longint'(h2_cfg) * src + (up + dn + lf + rt) * 64'sd65536;
    q = (num + 64'sd131072) >>> 18;
    if (q > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (q < -64'sd2147483648) return 32'h8000_0000;
    return q[31:0];
  endfunction

  function automatic bit predict_node(input bit first, input logic signed [31:0] u,
                                      input logic signed [31:0] f,
                                      output relax_result_t res);
    int unsigned side, r, c;
    longint      src_above;
    bit          hit, update;
    side = clamped_side();
    r = at_row;
    c = at_col;
    hit = 1'b0;
    res = '0;
    if (first || r >= side || c >= side) begin
      r = 0;
      c = 0;
    end
    u_left = u_here;
    u_here = u_one_up[c];
    src_above = f_one_up[c];
    if (r >= 2 && c >= 1 && c + 2 <= side) begin
      update = 1'b1;
      if (mode_cfg == psrs_pkg::MODE_EVEN) update = ((r - 1 + c) % 2) == 0;
      else if (mode_cfg == psrs_pkg::MODE_ODD) update = ((r - 1 + c) % 2) == 1;
      res.row = 10'(r - 1);
      res.col = 10'(c);
      res.value = update ? stencil_average(u_two_up[c], longint'(u), u_left,
                                           u_one_up[c + 1], src_above)
                         : u_here[31:0];
      res.last = (r + 1 == side) && (c + 2 == side);
      hit = 1'b1;
    end
    u_two_up[c] = u_here;
    u_one_up[c] = longint'(u);
    f_one_up[c] = longint'(f);
    c++;
    if (c >= side) begin
      c = 0;
      r++;
      if (r >= side) r = 0;
    end
    at_row = r;
    at_col = c;
    return hit;
  endfunction

  function automatic logic [31:0] pick_value(input int unsigned flavour);
    case (flavour)
      0: return $urandom;
      1: return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
      default: begin
        case ($urandom_range(0, 3))
          0: return PEAK;
          1: return 32'h8000_0000;
          2: return 32'h0;
          default: return $urandom;
        endcase
      end
    endcase
  endfunction

  function automatic logic [31:0] pick_side();
    case ($urandom_range(0, 19))
      0: return $urandom_range(0, 2);
      1: return 32'd2047;
      2, 3, 4: return $urandom_range(9, 16);
      default: return $urandom_range(3, 8);
    endcase
  endfunction

  function automatic logic [31:0] pick_step();
    case ($urandom_range(0, 7))
      0: return 32'd0;
      1: return 32'h0001_0000;
      2: return 32'h0001_FFFF;
      3: return $urandom_range(0, 32'h0001_FFFF);
      default: return $urandom_range(1, 32'h0000_4000);
    endcase
  endfunction

  function automatic void check_field(input string field, input logic [31:0] want, got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
      mismatches++;
    end
  endfunction

  task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      psrs_pkg::REG_GRID_SIDE:  side_cfg = value[10:0];
      psrs_pkg::REG_STEP_SQ:    h2_cfg = value[16:0];
      psrs_pkg::REG_SWEEP_MODE: mode_cfg = value[1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_node(input bit first, input logic [31:0] u, input logic [31:0] f,
                           input bit typed, input logic [31:0] want, input bit want_last);
    relax_result_t res;
    if (gaps_on && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid <= 1'b1;
    first_node <= first;
    solution_value <= u;
    source_value <= f;
    do @(posedge clk); while (in_stall);
    if (predict_node(first, u, f, res)) begin
      if (typed) begin
        res.value = want;
        res.last = want_last;
      end
      pending_results.push_back(res);
    end
  endtask

  always @(posedge clk) begin
    if (stall_cycles > 1) begin
      stall_cycles <= stall_cycles - 1;
    end else if (stall_cycles == 1) begin
      stall_cycles <= 0;
      out_stall <= 1'b0;
    end else if (stall_on && $urandom_range(0, 11) == 0) begin
      stall_cycles <= $urandom_range(1, 16);
      out_stall <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    relax_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result transaction: row %0d col %0d value %h last %b",
                 $time, node_row, node_col, relaxed_value, last_node);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("node_row", 32'(want.row), 32'(node_row));
        check_field("node_col", 32'(want.col), 32'(node_col));
        check_field("relaxed_value", want.value, relaxed_value);
        check_field("last_node", 32'(want.last), 32'(last_node));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("[poisson_stencil_relaxation_sweep] ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned random_nodes, phase, side, total, count, flavour, shape, i;
    bit          first, calm;
    random_nodes = 0;
    phase = 0;
    directed_rows = '{
      '{ROW_CFG, psrs_pkg::REG_GRID_SIDE, 32'd3, 0, 0, 0, 0, 0, 0},
      '{ROW_CFG, psrs_pkg::REG_STEP_SQ, ONE, 0, 0, 0, 0, 0, 0},
      '{ROW_CFG, psrs_pkg::REG_SWEEP_MODE, psrs_pkg::MODE_FULL, 0, 0, 0, 0, 0, 0},
      '{ROW_NODE, 0, 0, 1, 32'h0, 32'h0, 0, 0, 0},
      '{ROW_NODE, 0, 0, 0, ONE, 32'h0, 0, 0, 0},
      '{ROW_NODE, 0, 0, 0, 32'h0, 32'h0, 0, 0, 0},
      '{ROW_NODE, 0, 0, 0, 32'h0002_0000, 32'h0, 0, 0, 0},
      '{ROW_NODE, 0, 0, 0, 32'h0007_0000, 32'h0006_0000, 0, 0, 0},
      '{ROW_NODE, 0, 0, 0, 32'h0003_0000, 32'h0, 0, 0, 0},
      '{ROW_NODE, 0, 0, 0, 32'h0, 32'h0, 0, 0, 0},
      '{ROW_NODE, 0, 0, 0, 32'h0004_0000, 32'h0, 1, 32'h0004_0000, 1},
      '{ROW_CFG, psrs_pkg::REG_SWEEP_MODE, psrs_pkg::MODE_ODD, 0, 0, 0, 0, 0, 0},
      '{ROW_NODE, 0, 0, 1, 32'h0, 32'h0, 0, 0, 0},
      '{ROW_NODE, 0, 0, 0, ONE, 32'h0, 0, 0, 0},
      '{ROW_NODE, 0, 0, 0, 32'h0, 32'h0, 0, 0, 0},
      '{ROW_NODE, 0, 0, 0, 32'h0002_0000, 32'h0, 0, 0, 0},
      '{ROW_NODE, 0, 0, 0, 32'h0007_0000, 32'h0006_0000, 0, 0, 0},
      '{ROW_NODE, 0, 0, 0, 32'h0003_0000, 32'h0, 0, 0, 0},
      '{ROW_NODE, 0, 0, 0, 32'h0, 32'h0, 0, 0, 0},
      '{ROW_NODE, 0, 0, 0, 32'h0004_0000, 32'h0, 1, 32'h0007_0000, 1},
      '{ROW_CFG, psrs_pkg::REG_GRID_SIDE, 32'd0, 0, 0, 0, 0, 0, 0},
      '{ROW_CFG, psrs_pkg::REG_SWEEP_MODE, MODE_SPARE, 0, 0, 0, 0, 0, 0},
      '{ROW_NODE, 0, 0, 1, PEAK, PEAK, 0, 0, 0},
      '{ROW_NODE, 0, 0, 0, PEAK, PEAK, 0, 0, 0},
      '{ROW_NODE, 0, 0, 0, PEAK, PEAK, 0, 0, 0},
      '{ROW_NODE, 0, 0, 0, PEAK, PEAK, 0, 0, 0},
      '{ROW_NODE, 0, 0, 0, PEAK, PEAK, 0, 0, 0},
      '{ROW_NODE, 0, 0, 0, PEAK, PEAK, 0, 0, 0},
      '{ROW_NODE, 0, 0, 0, PEAK, PEAK, 0, 0, 0},
      '{ROW_NODE, 0, 0, 0, PEAK, PEAK, 1, PEAK, 1}
    };

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    gaps_on = 1'b1;
    stall_on = 1'b1;

    foreach (directed_rows[k]) begin
      if (directed_rows[k].kind == ROW_CFG) begin
        settle();
        write_register(directed_rows[k].idx, directed_rows[k].wdata);
      end else begin
        send_node(directed_rows[k].first, directed_rows[k].u, directed_rows[k].f,
                  directed_rows[k].typed, directed_rows[k].want, directed_rows[k].want_last);
      end
    end

    while (random_nodes < RANDOM_NODES) begin
      settle();
      calm = random_nodes >= CALM_FROM;
      gaps_on = !calm && $urandom_range(0, 3) != 0;
      stall_on = !calm && $urandom_range(0, 3) != 0;
      phase++;

      if (phase == 6) begin
        // A larger grid run far enough to reach its interior rows, then a
        // shrink that leaves the stream position outside the new grid.
        write_register(psrs_pkg::REG_GRID_SIDE, SHRINK_FROM);
        for (i = 0; i < 2 * SHRINK_FROM + 40; i++) begin
          send_node(i == 0, pick_value(1), pick_value(1), 0, 0, 0);
          random_nodes++;
        end
        settle();
        write_register(psrs_pkg::REG_GRID_SIDE, 32'd5);
        for (i = 0; i < 25; i++) begin
          send_node(1'b0, pick_value(0), pick_value(0), 0, 0, 0);
          random_nodes++;
        end
        settle();
      end

      if ($urandom_range(0, 1) == 0) write_register(psrs_pkg::REG_GRID_SIDE, pick_side());
      if ($urandom_range(0, 1) == 0) write_register(psrs_pkg::REG_STEP_SQ, pick_step());
      if ($urandom_range(0, 1) == 0)
        write_register(psrs_pkg::REG_SWEEP_MODE, $urandom_range(0, 3));

      repeat ($urandom_range(1, 3)) begin
        side = clamped_side();
        total = side * side;
        flavour = $urandom_range(0, 2);
        shape = $urandom_range(0, 9);
        if (side > 16) count = $urandom_range(1, 64);
        else if (shape == 8) count = $urandom_range(1, total);
        else count = total;
        for (i = 0; i < count && random_nodes < RANDOM_NODES; i++) begin
          if (shape == 9) first = $urandom_range(0, 15) == 0;
          else if (shape == 7) first = 1'b0;
          else first = (i == 0);
          send_node(first, pick_value(flavour), pick_value(flavour), 0, 0, 0);
          random_nodes++;
        end
      end
    end

    settle();
    repeat (16) @(posedge clk);
    if (mismatches == 0) $display("[poisson_stencil_relaxation_sweep] OK");
    else $display("[poisson_stencil_relaxation_sweep] ERROR");
    $finish;
  end

endmodule
